@@ hw/rtl/burst_header_fec_length_decoder_top_assert.svh @@
// Assertion macros for the burst header decoder checker.
`ifndef BURST_HEADER_FEC_LENGTH_DECODER_TOP_ASSERT_SVH
`define BURST_HEADER_FEC_LENGTH_DECODER_TOP_ASSERT_SVH

// Implication within the same cycle, masked while reset is low.
`define BHFL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Delayed implication, masked while reset is low.
`define BHFL_ASSERT_DLY(label, clk, rst_n, ante, lat, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(lat) (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bhfl_pkg.sv @@
package bhfl_pkg;

  // Field widths
  localparam int HDR_W      = 25;
  localparam int KEEP_W     = 22;
  localparam int LEN_W      = 17;
  localparam int SYND_W     = 5;
  localparam int WGT_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int OCT_W      = 15;
  localparam int BLK_W      = 7;
  localparam int LAST_W     = 8;
  localparam int FEC_W      = 9;
  localparam int REQ_W      = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int FEC_SUM_W  = 32;

  // Code block geometry
  localparam int BLOCK_TOTAL = 255;
  localparam int BLOCK_DATA  = 249;
  localparam logic [FEC_SUM_W-1:0] FEC_PER_BLK = FEC_SUM_W'(BLOCK_TOTAL - BLOCK_DATA);
  localparam int DATA_W = $clog2(BLOCK_DATA + 1);
  localparam int REM_W  = DATA_W + 1;

  // Reciprocal for the divide by the block data size
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = (1 << RECIP_SHIFT) / BLOCK_DATA;
  localparam int PROD_W      = OCT_W + RECIP_SHIFT;

  // Parity octets for a partial last block
  localparam int TAIL_W = 3;
  localparam int TAIL_T1 = 3;
  localparam int TAIL_T2 = 31;
  localparam int TAIL_T3 = 68;
  localparam logic [TAIL_W-1:0] TAIL_P0 = 3'd0;
  localparam logic [TAIL_W-1:0] TAIL_P1 = 3'd2;
  localparam logic [TAIL_W-1:0] TAIL_P2 = 3'd4;
  localparam logic [TAIL_W-1:0] TAIL_P3 = 3'd6;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RESV  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LONG  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd3;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_CLEAN = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_CORR  = 2'd1;
  localparam logic [CFG_DATA_W-1:0] LEN_CLEAN_RST = 17'h03FFF;
  localparam logic [CFG_DATA_W-1:0] LEN_CORR_RST  = 17'h01FFF;

  // Input word to result word, in cycles
  localparam int PIPE_LAT = 7;

  // Parity check rows; index 4 gives the syndrome msb
  localparam logic [SYND_W-1:0][HDR_W-1:0] CHECK_ROWS = {
    25'h0001FF0, 25'h07E1FE8, 25'h18E61E4, 25'h1B6A662, 25'h0D3CAA1
  };

  // Decoded header passed from the front end to the length arithmetic
  typedef struct packed {
    logic                vld;
    logic                resv_bad;
    logic                len_over;
    logic [SYND_W-1:0]   syndrome;
    logic [WGT_W-1:0]    weight;
    logic [LEN_W-1:0]    len;
    logic [OCT_W-1:0]    octs;
  } hdr_res_t;

  // Correction pattern for each syndrome
  function automatic logic [HDR_W-1:0] fix_pattern(input logic [SYND_W-1:0] s);
    logic [HDR_W-1:0] p;
    case (s)
      5'd0:  p = 25'h0000000;
      5'd1:  p = 25'h0000001;
      5'd2:  p = 25'h0000002;
      5'd3:  p = 25'h0800004;
      5'd4:  p = 25'h0000004;
      5'd5:  p = 25'h0800002;
      5'd6:  p = 25'h1000000;
      5'd7:  p = 25'h0800000;
      5'd8:  p = 25'h0000008;
      5'd9:  p = 25'h0400000;
      5'd10: p = 25'h0200000;
      5'd11: p = 25'h0100000;
      5'd12: p = 25'h0080000;
      5'd13: p = 25'h1100000;
      5'd14: p = 25'h0040000;
      5'd15: p = 25'h0020000;
      5'd16: p = 25'h0000010;
      5'd17: p = 25'h0010000;
      5'd18: p = 25'h0804000;
      5'd19: p = 25'h0008000;
      5'd20: p = 25'h0808000;
      5'd21: p = 25'h0004000;
      5'd22: p = 25'h0002000;
      5'd23: p = 25'h1010000;
      5'd24: p = 25'h0001000;
      5'd25: p = 25'h0000800;
      5'd26: p = 25'h0000400;
      5'd27: p = 25'h0000200;
      5'd28: p = 25'h0000100;
      5'd29: p = 25'h0000080;
      5'd30: p = 25'h0000040;
      5'd31: p = 25'h0000020;
      default: p = '0;
    endcase
    return p;
  endfunction

  // Number of bits the pattern corrects
  function automatic logic [WGT_W-1:0] fix_weight(input logic [SYND_W-1:0] s);
    logic [WGT_W-1:0] w;
    case (s)
      5'd0:                                  w = 2'd0;
      5'd3, 5'd5, 5'd13, 5'd18, 5'd20, 5'd23: w = 2'd2;
      default:                               w = 2'd1;
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/bhfl_hdr_fix.sv @@
module bhfl_hdr_fix (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic [bhfl_pkg::HDR_W-1:0]       in_hdr,
  input  logic [bhfl_pkg::CFG_DATA_W-1:0]  max_clean,
  input  logic [bhfl_pkg::CFG_DATA_W-1:0]  max_corr,
  output bhfl_pkg::hdr_res_t               res
);
  import bhfl_pkg::*;

  logic                vld1_r;
  logic [KEEP_W-1:0]   keep1_r;
  logic [SYND_W-1:0]   synd1_r;
  logic [KEEP_W-1:0]   keep_nxt;
  logic [SYND_W-1:0]   synd_nxt;
  logic [HDR_W-1:0]    fixed;
  logic [LEN_W-1:0]    len_f;
  logic [LEN_W:0]      len_sum;
  hdr_res_t            res_nxt;
  hdr_res_t            res_r;

  // Drop the reserved bits and form the syndrome
  always_comb begin
    keep_nxt = in_hdr[KEEP_W-1:0];
    for (int k = 0; k < SYND_W; k++) begin
      synd_nxt[k] = ^(keep_nxt & CHECK_ROWS[k][KEEP_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r  <= in_vld;
      keep1_r <= keep_nxt;
      synd1_r <= synd_nxt;
    end
  end

  // Apply the correction, reverse the length and check the limits
  always_comb begin
    fixed = {{(HDR_W-KEEP_W){1'b0}}, keep1_r} ^ fix_pattern(synd1_r);
    for (int i = 0; i < LEN_W; i++) begin
      len_f[i] = fixed[SYND_W + LEN_W - 1 - i];
    end
    len_sum = {1'b0, len_f} + (LEN_W+1)'(7);
    res_nxt.vld      = vld1_r;
    res_nxt.resv_bad = |fixed[HDR_W-1:KEEP_W];
    res_nxt.len_over = ((synd1_r != '0) && (len_f > max_corr)) || (len_f > max_clean);
    res_nxt.syndrome = synd1_r;
    res_nxt.weight   = fix_weight(synd1_r);
    res_nxt.len      = len_f;
    res_nxt.octs     = len_sum[LEN_W:3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.vld <= 1'b0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ hw/rtl/bhfl_len_calc.sv @@
module bhfl_len_calc (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bhfl_pkg::hdr_res_t              hdr,
  output logic                            out_strobe,
  output logic [bhfl_pkg::STATUS_W-1:0]   out_status,
  output logic [bhfl_pkg::SYND_W-1:0]     out_syndrome,
  output logic [bhfl_pkg::WGT_W-1:0]      out_syndrome_weight,
  output logic [bhfl_pkg::LEN_W-1:0]      out_length_bits,
  output logic [bhfl_pkg::OCT_W-1:0]      out_length_octets,
  output logic [bhfl_pkg::BLK_W-1:0]      out_block_count,
  output logic [bhfl_pkg::LAST_W-1:0]     out_last_block_octets,
  output logic [bhfl_pkg::FEC_W-1:0]      out_fec_octets,
  output logic [bhfl_pkg::REQ_W-1:0]      out_requested_bits
);
  import bhfl_pkg::*;

  localparam int QD_W = OCT_W + DATA_W;

  // Stage registers
  hdr_res_t               s3_h_r, s4_h_r, s5_h_r, s6_h_r;
  logic [PROD_W-1:0]      s3_prod_r;
  logic [OCT_W-1:0]       s4_q_r, s5_q_r;
  logic [REM_W-1:0]       s4_r_r;
  logic [DATA_W-1:0]      s5_last_r, s6_last_r;
  logic [TAIL_W-1:0]      s5_tail_r;
  logic [FEC_SUM_W-1:0]   s6_fec_r;
  logic [BLK_W-1:0]       s6_blk_r;

  logic                   strobe_r;
  logic [STATUS_W-1:0]    status_r;
  logic [SYND_W-1:0]      synd_r;
  logic [WGT_W-1:0]       wgt_r;
  logic [LEN_W-1:0]       len_r;
  logic [OCT_W-1:0]       octs_r;
  logic [BLK_W-1:0]       blk_r;
  logic [LAST_W-1:0]      last_r;
  logic [FEC_W-1:0]       fec_r;
  logic [REQ_W-1:0]       req_r;

  // Combinational values between stages
  logic [PROD_W-1:0]      prod_nxt;
  logic [OCT_W-1:0]       q0;
  logic [QD_W-1:0]        qd;
  logic [QD_W-1:0]        r_full;
  logic [OCT_W-1:0]       q_nxt;
  logic [REM_W-1:0]       r_nxt;
  logic [TAIL_W-1:0]      tail_nxt;
  logic [FEC_SUM_W-1:0]   fec_nxt;
  logic [BLK_W-1:0]       blk_nxt;
  logic [FEC_SUM_W-1:0]   sum_nxt;
  logic                   drop_len;
  logic                   drop_oct;
  logic [STATUS_W-1:0]    status_nxt;

  // Stage 3: multiply the octet count by the reciprocal
  assign prod_nxt = PROD_W'(hdr.octs) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_h_r.vld <= 1'b0;
    end else begin
      s3_h_r    <= hdr;
      s3_prod_r <= prod_nxt;
    end
  end

  // Stage 4: estimate quotient and remainder
  always_comb begin
    q0     = s3_prod_r[PROD_W-1:RECIP_SHIFT];
    qd     = QD_W'(q0) * QD_W'(BLOCK_DATA);
    r_full = QD_W'(s3_h_r.octs) - qd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_h_r.vld <= 1'b0;
    end else begin
      s4_h_r <= s3_h_r;
      s4_q_r <= q0;
      s4_r_r <= r_full[REM_W-1:0];
    end
  end

  // Stage 5: correct the estimate by one and pick the tail parity
  always_comb begin
    if (s4_r_r >= REM_W'(BLOCK_DATA)) begin
      q_nxt = s4_q_r + OCT_W'(1);
      r_nxt = s4_r_r - REM_W'(BLOCK_DATA);
    end else begin
      q_nxt = s4_q_r;
      r_nxt = s4_r_r;
    end
    if (32'(r_nxt) < TAIL_T1) begin
      tail_nxt = TAIL_P0;
    end else if (32'(r_nxt) < TAIL_T2) begin
      tail_nxt = TAIL_P1;
    end else if (32'(r_nxt) < TAIL_T3) begin
      tail_nxt = TAIL_P2;
    end else begin
      tail_nxt = TAIL_P3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_h_r.vld <= 1'b0;
    end else begin
      s5_h_r    <= s4_h_r;
      s5_q_r    <= q_nxt;
      s5_last_r <= r_nxt[DATA_W-1:0];
      s5_tail_r <= tail_nxt;
    end
  end

  // Stage 6: parity octets and block count
  always_comb begin
    fec_nxt = FEC_SUM_W'(s5_q_r) * FEC_PER_BLK + FEC_SUM_W'(s5_tail_r);
    blk_nxt = BLK_W'(s5_q_r) + BLK_W'(s5_last_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_h_r.vld <= 1'b0;
    end else begin
      s6_h_r    <= s5_h_r;
      s6_fec_r  <= fec_nxt;
      s6_blk_r  <= blk_nxt;
      s6_last_r <= s5_last_r;
    end
  end

  // Stage 7: status, requested bits and masking of rejected fields
  always_comb begin
    sum_nxt  = FEC_SUM_W'(s6_h_r.octs) + s6_fec_r;
    drop_len = s6_h_r.resv_bad;
    drop_oct = s6_h_r.resv_bad || s6_h_r.len_over;
    if (s6_h_r.resv_bad) begin
      status_nxt = STATUS_RESV;
    end else if (s6_h_r.len_over) begin
      status_nxt = STATUS_LONG;
    end else if (s6_fec_r == '0) begin
      status_nxt = STATUS_SHORT;
    end else begin
      status_nxt = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= s6_h_r.vld;
      status_r <= status_nxt;
      synd_r   <= s6_h_r.syndrome;
      wgt_r    <= s6_h_r.weight;
      len_r    <= drop_len ? '0 : s6_h_r.len;
      octs_r   <= drop_oct ? '0 : s6_h_r.octs;
      blk_r    <= drop_oct ? '0 : s6_blk_r;
      last_r   <= drop_oct ? '0 : LAST_W'(s6_last_r);
      fec_r    <= drop_oct ? '0 : s6_fec_r[FEC_W-1:0];
      req_r    <= (status_nxt == STATUS_OK) ? {sum_nxt[REQ_W-4:0], 3'b000} : '0;
    end
  end

  assign out_strobe            = strobe_r;
  assign out_status            = status_r;
  assign out_syndrome          = synd_r;
  assign out_syndrome_weight   = wgt_r;
  assign out_length_bits       = len_r;
  assign out_length_octets     = octs_r;
  assign out_block_count       = blk_r;
  assign out_last_block_octets = last_r;
  assign out_fec_octets        = fec_r;
  assign out_requested_bits    = req_r;

endmodule

@@ hw/rtl/burst_header_fec_length_decoder_top.sv @@
// Burst header FEC and length decoder.
// Throughput: one header word per cycle through a seven stage pipeline; busy is low
// whenever reset is released and results are never held back, as the receiver cannot stall.
// Reset (synchronous, active low) empties the pipeline and restores both length limits.
module burst_header_fec_length_decoder_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [bhfl_pkg::HDR_W-1:0]        in_header_word,
  output logic                              out_strobe,
  output logic [bhfl_pkg::STATUS_W-1:0]     out_status,
  output logic [bhfl_pkg::SYND_W-1:0]       out_syndrome,
  output logic [bhfl_pkg::WGT_W-1:0]        out_syndrome_weight,
  output logic [bhfl_pkg::LEN_W-1:0]        out_length_bits,
  output logic [bhfl_pkg::OCT_W-1:0]        out_length_octets,
  output logic [bhfl_pkg::BLK_W-1:0]        out_block_count,
  output logic [bhfl_pkg::LAST_W-1:0]       out_last_block_octets,
  output logic [bhfl_pkg::FEC_W-1:0]        out_fec_octets,
  output logic [bhfl_pkg::REQ_W-1:0]        out_requested_bits,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bhfl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bhfl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bhfl_pkg::*;

  logic [CFG_DATA_W-1:0] max_clean_r;
  logic [CFG_DATA_W-1:0] max_corr_r;
  logic                  in_vld;
  hdr_res_t              hdr_res;

  // Take a word whenever out of reset
  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign in_vld    = start & ~busy;

  // Length limit registers; ignore writes beyond the register list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_clean_r <= LEN_CLEAN_RST;
      max_corr_r  <= LEN_CORR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_CLEAN: max_clean_r <= cfg_data;
        CFG_IDX_CORR:  max_corr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  bhfl_hdr_fix u_hdr_fix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_vld),
    .in_hdr    (in_header_word),
    .max_clean (max_clean_r),
    .max_corr  (max_corr_r),
    .res       (hdr_res)
  );

  bhfl_len_calc u_len_calc (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .hdr                   (hdr_res),
    .out_strobe            (out_strobe),
    .out_status            (out_status),
    .out_syndrome          (out_syndrome),
    .out_syndrome_weight   (out_syndrome_weight),
    .out_length_bits       (out_length_bits),
    .out_length_octets     (out_length_octets),
    .out_block_count       (out_block_count),
    .out_last_block_octets (out_last_block_octets),
    .out_fec_octets        (out_fec_octets),
    .out_requested_bits    (out_requested_bits)
  );

endmodule

@@ hw/rtl/bhfl_checker.sv @@
`include "burst_header_fec_length_decoder_top_assert.svh"

module bhfl_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [bhfl_pkg::HDR_W-1:0]        in_header_word,
  input logic                              out_strobe,
  input logic [bhfl_pkg::STATUS_W-1:0]     out_status,
  input logic [bhfl_pkg::SYND_W-1:0]       out_syndrome,
  input logic [bhfl_pkg::WGT_W-1:0]        out_syndrome_weight,
  input logic [bhfl_pkg::LEN_W-1:0]        out_length_bits,
  input logic [bhfl_pkg::OCT_W-1:0]        out_length_octets,
  input logic [bhfl_pkg::BLK_W-1:0]        out_block_count,
  input logic [bhfl_pkg::LAST_W-1:0]       out_last_block_octets,
  input logic [bhfl_pkg::FEC_W-1:0]        out_fec_octets,
  input logic [bhfl_pkg::REQ_W-1:0]        out_requested_bits,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [bhfl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [bhfl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bhfl_pkg::*;

  // Every word taken leaves as a result after the pipeline latency
  `BHFL_ASSERT_DLY(a_word_out, clk, rst_n, start && !busy, PIPE_LAT, out_strobe, "word lost in pipeline")

  // No result without a word taken the same latency earlier
  `BHFL_ASSERT_IMP(a_no_spurious, clk, rst_n, out_strobe, $past(start && !busy, PIPE_LAT), "result without word")

  // A rejected reserved field clears the length
  `BHFL_ASSERT_IMP(a_resv_clear, clk, rst_n, out_strobe && (out_status == STATUS_RESV), (out_length_bits == '0) && (out_requested_bits == '0), "reserved reject not cleared")

  // A zero syndrome corrects nothing
  `BHFL_ASSERT_IMP(a_clean_weight, clk, rst_n, out_strobe && (out_syndrome == '0), out_syndrome_weight == '0, "weight without syndrome")

endmodule

bind burst_header_fec_length_decoder_top bhfl_checker u_bhfl_checker (.*);

@@ verif/burst_header_fec_length_decoder_top_tb.sv @@
`timescale 1ns / 100ps

module burst_header_fec_length_decoder_top_tb;

  localparam int HW = bhfl_pkg::HDR_W;
  localparam int LW = bhfl_pkg::LEN_W;

  localparam logic [HW-1:0] KEEP_MASK = 25'h03FFFFF;
  localparam logic [LW-1:0] LIMIT_MAX = 17'h1FFFF;
  localparam logic [LW-1:0] RST_CLEAN = 17'd16383;
  localparam logic [LW-1:0] RST_CORR  = 17'd8191;

  // Spare register indexes: writes there must leave both limits alone
  localparam logic [bhfl_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [bhfl_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  localparam int unsigned DATA_PER_BLOCK   = bhfl_pkg::BLOCK_DATA;
  localparam int unsigned PARITY_PER_BLOCK = bhfl_pkg::BLOCK_TOTAL - bhfl_pkg::BLOCK_DATA;

  localparam int STALL_LIMIT = 2000;

  // Check rows, index 4 drives the syndrome msb
  localparam logic [4:0][HW-1:0] PARITY_ROWS = {
    25'h0001FF0, 25'h07E1FE8, 25'h18E61E4, 25'h1B6A662, 25'h0D3CAA1
  };

  // Correction pattern per syndrome, listed from syndrome 31 down to 0
  localparam logic [31:0][HW-1:0] FIX_PATTERNS = {
    25'h0000020, 25'h0000040, 25'h0000080, 25'h0000100,
    25'h0000200, 25'h0000400, 25'h0000800, 25'h0001000,
    25'h1010000, 25'h0002000, 25'h0004000, 25'h0808000,
    25'h0008000, 25'h0804000, 25'h0010000, 25'h0000010,
    25'h0020000, 25'h0040000, 25'h1100000, 25'h0080000,
    25'h0100000, 25'h0200000, 25'h0400000, 25'h0000008,
    25'h0800000, 25'h1000000, 25'h0800002, 25'h0000004,
    25'h0800004, 25'h0000002, 25'h0000001, 25'h0000000
  };

  // Syndromes whose pattern flips two bits
  localparam logic [31:0] DOUBLE_FIX = 32'h0094_2028;

  typedef struct packed {
    logic [bhfl_pkg::STATUS_W-1:0] status;
    logic [bhfl_pkg::SYND_W-1:0]   syndrome;
    logic [bhfl_pkg::WGT_W-1:0]    weight;
    logic [bhfl_pkg::LEN_W-1:0]    length_bits;
    logic [bhfl_pkg::OCT_W-1:0]    length_octets;
    logic [bhfl_pkg::BLK_W-1:0]    block_count;
    logic [bhfl_pkg::LAST_W-1:0]   tail_octets;
    logic [bhfl_pkg::FEC_W-1:0]    parity_octets;
    logic [bhfl_pkg::REQ_W-1:0]    read_bits;
  } hdr_decode_t;

  typedef struct packed {
    logic [HW-1:0] header;
    hdr_decode_t   decode;
  } decode_entry_t;

  typedef struct packed {
    logic [bhfl_pkg::CFG_IDX_W-1:0]  index;
    logic [bhfl_pkg::CFG_DATA_W-1:0] data;
  } limit_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [HW-1:0] in_header_word = '0;
  logic out_strobe;
  logic [bhfl_pkg::STATUS_W-1:0] out_status;
  logic [bhfl_pkg::SYND_W-1:0]   out_syndrome;
  logic [bhfl_pkg::WGT_W-1:0]    out_syndrome_weight;
  logic [bhfl_pkg::LEN_W-1:0]    out_length_bits;
  logic [bhfl_pkg::OCT_W-1:0]    out_length_octets;
  logic [bhfl_pkg::BLK_W-1:0]    out_block_count;
  logic [bhfl_pkg::LAST_W-1:0]   out_last_block_octets;
  logic [bhfl_pkg::FEC_W-1:0]    out_fec_octets;
  logic [bhfl_pkg::REQ_W-1:0]    out_requested_bits;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bhfl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bhfl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the two length limits
  logic [LW-1:0] limit_clean = RST_CLEAN;
  logic [LW-1:0] limit_corr  = RST_CORR;

  logic [HW-1:0] pending_headers[$];
  decode_entry_t expected_decodes[$];
  limit_write_t  pending_writes[$];

  int headers_queued = 0;
  int headers_taken = 0;
  int writes_queued = 0;
  int writes_done = 0;
  int send_idle_pct = 34;
  int mismatch_count = 0;
  int stall_cycles = 0;

  hdr_decode_t   seen_decode;
  decode_entry_t want_entry;

  burst_header_fec_length_decoder_top i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_header_word        (in_header_word),
    .out_strobe            (out_strobe),
    .out_status            (out_status),
    .out_syndrome          (out_syndrome),
    .out_syndrome_weight   (out_syndrome_weight),
    .out_length_bits       (out_length_bits),
    .out_length_octets     (out_length_octets),
    .out_block_count       (out_block_count),
    .out_last_block_octets (out_last_block_octets),
    .out_fec_octets        (out_fec_octets),
    .out_requested_bits    (out_requested_bits),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [LW-1:0] reverse17(input logic [LW-1:0] v);
    logic [LW-1:0] r;
    for (int i = 0; i < LW; i++) r[LW-1-i] = v[i];
    return r;
  endfunction

  // Parity checks on the header with the reserved bits cleared
  function automatic logic [4:0] header_syndrome(input logic [HW-1:0] word);
    logic [HW-1:0] kept;
    logic [4:0] s;
    kept = word & KEEP_MASK;
    for (int i = 0; i < 5; i++) s[i] = ^(kept & PARITY_ROWS[i]);
    return s;
  endfunction

  // FEC bits are systematic: each sits in exactly one check row
  function automatic logic [HW-1:0] codeword(input logic [LW-1:0] len, input logic [2:0] resv);
    logic [HW-1:0] w;
    w = {resv, reverse17(len), 5'b00000};
    w[4:0] = header_syndrome(w);
    return w;
  endfunction

  function automatic hdr_decode_t predict_header(input logic [HW-1:0] word);
    hdr_decode_t r;
    logic [HW-1:0] fixed;
    logic [4:0] synd;
    logic [LW-1:0] len;
    int unsigned octs, blocks, tail, fec;
    r = '0;
    synd = header_syndrome(word);
    fixed = (word & KEEP_MASK) ^ FIX_PATTERNS[synd];
    r.syndrome = synd;
    r.weight = (synd == 5'd0) ? 2'd0 : (DOUBLE_FIX[synd] ? 2'd2 : 2'd1);
    // reject a header that the correction pushed into the reserved bits
    if (fixed[24:22] != 3'b000) begin
      r.status = bhfl_pkg::STATUS_RESV;
      return r;
    end
    len = reverse17(fixed[21:5]);
    r.length_bits = len;
    if ((synd != 5'd0 && len > limit_corr) || len > limit_clean) begin
      r.status = bhfl_pkg::STATUS_LONG;
      return r;
    end
    octs = len;
    octs = (octs + 7) >> 3;
    blocks = octs / DATA_PER_BLOCK;
    tail = octs % DATA_PER_BLOCK;
    fec = blocks * PARITY_PER_BLOCK;
    if (tail != 0) blocks++;
    if (tail >= 68) fec += 6;
    else if (tail >= 31) fec += 4;
    else if (tail >= 3) fec += 2;
    r.length_octets = bhfl_pkg::OCT_W'(octs);
    r.block_count = bhfl_pkg::BLK_W'(blocks);
    r.tail_octets = bhfl_pkg::LAST_W'(tail);
    r.parity_octets = bhfl_pkg::FEC_W'(fec);
    if (fec == 0) begin
      r.status = bhfl_pkg::STATUS_SHORT;
      return r;
    end
    r.read_bits = bhfl_pkg::REQ_W'(8 * (octs + fec));
    r.status = bhfl_pkg::STATUS_OK;
    return r;
  endfunction

  task automatic add_header(input logic [HW-1:0] w);
    pending_headers.push_back(w);
    headers_queued++;
  endtask

  task automatic add_write(input logic [bhfl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bhfl_pkg::CFG_DATA_W-1:0] val);
    pending_writes.push_back('{index: idx, data: val});
    writes_queued++;
  endtask

  // Both limits, sometimes a stray write to a spare index; block is idle here
  task automatic write_limits(input logic [LW-1:0] clean, input logic [LW-1:0] corr);
    add_write(bhfl_pkg::CFG_IDX_CLEAN, clean);
    if ($urandom_range(0, 1) == 0)
      add_write($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B, 17'($urandom));
    add_write(bhfl_pkg::CFG_IDX_CORR, corr);
    while (writes_done != writes_queued) @(posedge clk);
  endtask

  // Wait for every result, then let the pipeline settle
  task automatic drain_results();
    while (headers_taken != headers_queued || expected_decodes.size() != 0) @(posedge clk);
    repeat (bhfl_pkg::PIPE_LAT + 3) @(posedge clk);
  endtask

  // Random headers, some with lengths near the interesting edges, most with injected errors
  task automatic add_random_header();
    int l;
    int octs;
    int sel;
    logic [HW-1:0] w;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      l = $urandom_range(0, 600);
    end else if (sel < 5) begin
      l = ($urandom_range(0, 1) ? int'(limit_clean) : int'(limit_corr)) + $urandom_range(0, 6) - 3;
    end else if (sel < 7) begin
      octs = $urandom_range(0, 65) * DATA_PER_BLOCK;
      case ($urandom_range(0, 8))
        0: octs += 0;
        1: octs += 1;
        2: octs += 2;
        3: octs += 3;
        4: octs += 30;
        5: octs += 31;
        6: octs += 67;
        7: octs += 68;
        default: octs += 248;
      endcase
      l = octs * 8 - $urandom_range(0, 7);
    end else if (sel < 9) begin
      l = $urandom_range(0, 131071);
    end else begin
      l = $urandom_range(0, int'(limit_clean));
    end
    if (l < 0) l = 0;
    if (l > 131071) l = 131071;
    w = codeword(LW'(l), 3'($urandom));
    // inject errors: random flips in the FEC bits, one or two bit flips, or plain noise
    sel = $urandom_range(0, 9);
    if (sel >= 3 && sel < 6) begin
      w[4:0] = w[4:0] ^ 5'($urandom);
    end else if (sel >= 6 && sel < 8) begin
      w[$urandom_range(0, 21)] ^= 1'b1;
      if ($urandom_range(0, 1) == 0) w[$urandom_range(0, 21)] ^= 1'b1;
    end else if (sel >= 8) begin
      w = HW'($urandom);
    end
    add_header(w);
  endtask

  task automatic run_random_phase(input logic [LW-1:0] clean, input logic [LW-1:0] corr,
                                  input int idle_pct, input int count);
    write_limits(clean, corr);
    send_idle_pct = idle_pct;
    repeat (count) add_random_header();
    drain_results();
  endtask

  // Driver: input words and register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      limit_clean = RST_CLEAN;
      limit_corr = RST_CORR;
    end else begin
      if (start && !busy) begin
        expected_decodes.push_back('{header: in_header_word,
                                     decode: predict_header(in_header_word)});
        headers_taken++;
      end
      // offer the next word, or idle, once the current one is gone
      if (!start || !busy) begin
        if (pending_headers.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          start <= 1'b1;
          in_header_word <= pending_headers.pop_front();
        end else begin
          start <= 1'b0;
          in_header_word <= HW'($urandom);
        end
      end

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bhfl_pkg::CFG_IDX_CLEAN) limit_clean = cfg_data;
        else if (cfg_index == bhfl_pkg::CFG_IDX_CORR) limit_corr = cfg_data;
        writes_done++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (pending_writes.size() != 0) begin
          cfg_valid <= 1'b1;
          {cfg_index, cfg_data} <= pending_writes.pop_front();
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      seen_decode = {out_status, out_syndrome, out_syndrome_weight, out_length_bits,
                     out_length_octets, out_block_count, out_last_block_octets,
                     out_fec_octets, out_requested_bits};
      if (expected_decodes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result word with no header pending, status=%0d len=%0d",
                   out_status, out_length_bits);
      end else begin
        want_entry = expected_decodes.pop_front();
        if (seen_decode !== want_entry.decode) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("ERROR: header %h decoded wrongly", want_entry.header);
            $display("  exp st=%0d syn=%0d w=%0d len=%0d oct=%0d blk=%0d tail=%0d fec=%0d req=%0d",
                     want_entry.decode.status, want_entry.decode.syndrome,
                     want_entry.decode.weight, want_entry.decode.length_bits,
                     want_entry.decode.length_octets, want_entry.decode.block_count,
                     want_entry.decode.tail_octets, want_entry.decode.parity_octets,
                     want_entry.decode.read_bits);
            $display("  got st=%0d syn=%0d w=%0d len=%0d oct=%0d blk=%0d tail=%0d fec=%0d req=%0d",
                     seen_decode.status, seen_decode.syndrome, seen_decode.weight,
                     seen_decode.length_bits, seen_decode.length_octets,
                     seen_decode.block_count, seen_decode.tail_octets,
                     seen_decode.parity_octets, seen_decode.read_bits);
          end
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves on any channel
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limits: too short, tail edges, both limits, reserved rejects
    send_idle_pct = 34;
    add_header(codeword(17'd0, 3'b000));
    add_header(codeword(17'd16, 3'b000));
    add_header(codeword(17'd17, 3'b000));
    add_header(codeword(17'd16383, 3'b111));
    add_header(codeword(17'd16384, 3'b000));
    add_header(codeword(17'd8191, 3'b000) ^ 25'd1);
    add_header(codeword(17'd8192, 3'b000) ^ 25'd1);
    add_header(codeword(17'd100, 3'b000) ^ 25'd6);
    add_header(codeword(17'd100, 3'b101) ^ 25'd3);
    add_header(25'h0000000);
    add_header(25'h1FFFFFF);
    add_header(codeword(17'd200, 3'b010) ^ 25'd31);
    drain_results();

    // Widest limits: largest frame and octet counts around the tail steps at 31 and 68 and the block edge
    write_limits(LIMIT_MAX, LIMIT_MAX);
    add_write(CFG_IDX_SPARE_A, 17'd0);
    add_write(CFG_IDX_SPARE_B, LIMIT_MAX);
    while (writes_done != writes_queued) @(posedge clk);
    add_header(codeword(17'd131071, 3'b000));
    add_header(codeword(17'd131071, 3'b000) ^ 25'd16);
    add_header(codeword(17'd1, 3'b000));
    add_header(codeword(17'd240, 3'b000));
    add_header(codeword(17'd248, 3'b000));
    add_header(codeword(17'd536, 3'b000));
    add_header(codeword(17'd544, 3'b000));
    add_header(codeword(17'd1984, 3'b000));
    add_header(codeword(17'd1992, 3'b000));
    add_header(codeword(17'd2000, 3'b000));
    add_header(codeword(17'd65535, 3'b111) ^ 25'd23);
    drain_results();

    run_random_phase(RST_CLEAN, RST_CORR, 34, 330);
    run_random_phase(17'd0, 17'd0, 34, 150);
    run_random_phase(LIMIT_MAX, LIMIT_MAX, 68, 360);
    run_random_phase(17'($urandom), 17'($urandom), 68, 330);
    run_random_phase(17'd2000, LIMIT_MAX, 0, 330);
    run_random_phase(17'($urandom), 17'($urandom), 0, 330);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
